>>> rtl/core/ordered_block_list_defines.svh
// ----------------------------------------------------------------------------
// ordered_block_list_defines.svh
// Assertion macros for the ordered block list. Empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ORDERED_BLOCK_LIST_DEFINES_SVH
`define ORDERED_BLOCK_LIST_DEFINES_SVH

`ifndef SYNTH
// checked only outside reset
`define OBL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define OBL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBL_ASSERT(lbl, prop, msg)
`define OBL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/obl_pkg.sv
// ----------------------------------------------------------------------------
// obl_pkg
// Types, sizes and codes shared by the ordered block list modules.
// ----------------------------------------------------------------------------
package obl_pkg;

  // list geometry
  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_CNT_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
  localparam logic [OP_W-1:0] OP_PREPEND    = 3'd1;
  localparam logic [OP_W-1:0] OP_REM_FIRST  = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_LAST   = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
  localparam logic [OP_W-1:0] OP_MOVE_END   = 3'd5;
  localparam logic [OP_W-1:0] OP_MOVE_FRONT = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // per-cell commands
  typedef logic [1:0] cell_cmd_t;
  localparam cell_cmd_t CMD_HOLD       = 2'd0;
  localparam cell_cmd_t CMD_LOAD       = 2'd1;
  localparam cell_cmd_t CMD_FROM_LEFT  = 2'd2;
  localparam cell_cmd_t CMD_FROM_RIGHT = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [HANDLE_BITS-1:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle_out;
    logic [STATUS_W-1:0]    status;
    logic                   now_empty;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } out_item_t;

  // control into one cell
  typedef struct packed {
    cell_cmd_t              cmd;
    logic [HANDLE_BITS-1:0] key;
  } cell_ctrl_t;

  // decoder result back to the top level
  typedef struct packed {
    out_item_t        item;
    logic [CNT_W-1:0] count_nxt;
  } ctrl_result_t;

endpackage

>>> rtl/core/obl_cell.sv
// ----------------------------------------------------------------------------
// obl_cell
// One list slot: holds a handle, compares it with the request key and
// loads, holds or takes a neighbor's handle as commanded.
// ----------------------------------------------------------------------------
module obl_cell
  import obl_pkg::*;
(
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [HANDLE_BITS-1:0] left_data,
  input  logic [HANDLE_BITS-1:0] right_data,
  output logic [HANDLE_BITS-1:0] data,
  output logic                   match
);

  logic [HANDLE_BITS-1:0] data_r;
  logic [HANDLE_BITS-1:0] data_nxt;

  // next slot contents
  always_comb begin
    case (ctrl.cmd)
      CMD_LOAD:       data_nxt = ctrl.key;
      CMD_FROM_LEFT:  data_nxt = left_data;
      CMD_FROM_RIGHT: data_nxt = right_data;
      default:        data_nxt = data_r;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == ctrl.key);

endmodule

>>> rtl/core/obl_ctrl.sv
// ----------------------------------------------------------------------------
// obl_ctrl
// Operation decoder: finds the front-most hit, picks a command for every
// cell and forms the result and the next entry count.
// ----------------------------------------------------------------------------
module obl_ctrl
  import obl_pkg::*;
(
  input  logic                   fire,
  input  in_item_t               req,
  input  logic [CNT_W-1:0]       count_r,
  input  logic [HANDLE_BITS-1:0] cell_data  [CAPACITY],
  input  logic [CAPACITY-1:0]    cell_match,
  output cell_cmd_t              cell_cmd   [CAPACITY],
  output ctrl_result_t           res
);

  logic [CAPACITY-1:0]    hit;
  logic [CAPACITY-1:0]    first;
  logic [CAPACITY-1:0]    at_or_after;
  logic [CAPACITY-1:0]    at_or_before;
  logic                   found;
  logic                   empty;
  logic                   full;
  logic                   null_h;
  logic                   ok;
  logic [HANDLE_BITS-1:0] last_data;
  logic [HANDLE_BITS-1:0] taken;
  logic [STATUS_W-1:0]    status;
  logic [CNT_W-1:0]       count_nxt;

  assign empty  = (count_r == '0);
  assign full   = (count_r >= CNT_W'(CAPACITY));
  assign null_h = (req.handle == '0);

  // hits inside the filled range, front-most one, and its range masks
  always_comb begin
    logic below;
    logic seen;
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = cell_match[i] && (CNT_W'(i) < count_r);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      below = 1'b0;
      for (int j = 0; j < i; j++) begin
        below = below | hit[j];
      end
      first[i] = hit[i] && !below;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      seen = 1'b0;
      for (int j = 0; j <= i; j++) begin
        seen = seen | first[j];
      end
      at_or_after[i] = seen;
      seen = 1'b0;
      for (int j = i; j < CAPACITY; j++) begin
        seen = seen | first[j];
      end
      at_or_before[i] = seen;
    end
    found = |hit;
  end

  // handle in the last filled slot
  always_comb begin
    last_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i + 1) == count_r) last_data = last_data | cell_data[i];
    end
  end

  // status, count and taken handle
  always_comb begin
    ok        = 1'b0;
    status    = ST_OK;
    taken     = '0;
    count_nxt = count_r;
    unique case (req.op) inside
      OP_APPEND, OP_PREPEND: begin
        if (null_h) status = ST_NOT_FOUND;
        else if (full) status = ST_FULL;
        else begin
          ok        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REM_FIRST, OP_REM_LAST: begin
        if (empty) status = ST_EMPTY;
        else begin
          ok        = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          taken     = (req.op == OP_REM_FIRST) ? cell_data[0] : last_data;
        end
      end
      OP_REMOVE, OP_MOVE_END, OP_MOVE_FRONT: begin
        if (empty) status = ST_EMPTY;
        else if (null_h || !found) status = ST_NOT_FOUND;
        else begin
          ok = 1'b1;
          if (req.op == OP_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
            taken     = req.handle;
          end
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  // per-cell commands
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_cmd[i] = CMD_HOLD;
      if (fire && ok) begin
        case (req.op)
          OP_APPEND: begin
            if (CNT_W'(i) == count_r) cell_cmd[i] = CMD_LOAD;
          end
          OP_PREPEND: begin
            cell_cmd[i] = (i == 0) ? CMD_LOAD : CMD_FROM_LEFT;
          end
          OP_REM_FIRST: begin
            if (i < CAPACITY - 1) cell_cmd[i] = CMD_FROM_RIGHT;
          end
          OP_REMOVE: begin
            if (at_or_after[i]) cell_cmd[i] = CMD_FROM_RIGHT;
          end
          OP_MOVE_END: begin
            // close the gap, then put the handle back in the last slot
            if (CNT_W'(i + 1) == count_r) cell_cmd[i] = CMD_LOAD;
            else if (at_or_after[i] && (CNT_W'(i + 1) < count_r)) cell_cmd[i] = CMD_FROM_RIGHT;
          end
          OP_MOVE_FRONT: begin
            if (i == 0) cell_cmd[i] = CMD_LOAD;
            else if (at_or_before[i]) cell_cmd[i] = CMD_FROM_LEFT;
          end
          default: cell_cmd[i] = CMD_HOLD;
        endcase
      end
    end
  end

  assign res.item.handle_out  = taken;
  assign res.item.status      = status;
  assign res.item.now_empty   = (count_nxt == '0);
  assign res.item.entry_count = ENTRY_CNT_W'(count_nxt);
  assign res.count_nxt        = count_nxt;

endmodule

>>> rtl/core/ordered_block_list.sv
// ----------------------------------------------------------------------------
// ordered_block_list
// Replacement-order list of cache block handles held in a chain of cells.
//
//   channel | direction | ports                          | moves
//   in      | input     | in_valid, in_ready, in_data    | op and handle
//   out     | output    | out_valid, out_ready, out_data | one result request
//
// One request is accepted per cycle while in_ready is high; its result is in
// the output register in the next cycle. The rate is set by the parallel key
// compare across all cells and the one-step shift of the chain. in_ready drops
// only while a result waits in the output register and out_ready is low. Reset
// clears the entry count and the output valid; cell contents are not reset.
// ----------------------------------------------------------------------------
`include "ordered_block_list_defines.svh"

module ordered_block_list
  import obl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [CNT_W-1:0]       count_r;
  logic                   out_valid_r;
  out_item_t              out_r;
  logic                   fire;
  logic                   insert_ok;
  logic                   clear_req;
  logic [HANDLE_BITS-1:0] cell_data  [CAPACITY];
  logic [HANDLE_BITS-1:0] left_d     [CAPACITY];
  logic [HANDLE_BITS-1:0] right_d    [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;
  cell_cmd_t              cell_cmd   [CAPACITY];
  cell_ctrl_t             cell_ctrl  [CAPACITY];
  ctrl_result_t           res;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  // decoder
  obl_ctrl u_ctrl (
    .fire       (fire),
    .req        (in_data),
    .count_r    (count_r),
    .cell_data  (cell_data),
    .cell_match (cell_match),
    .cell_cmd   (cell_cmd),
    .res        (res)
  );

  // chain of cells; the end cells see the key at their open side
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign cell_ctrl[g] = '{cmd: cell_cmd[g], key: in_data.handle};
    if (g == 0) begin : g_first
      assign left_d[g] = in_data.handle;
    end else begin : g_inner_l
      assign left_d[g] = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d[g] = in_data.handle;
    end else begin : g_inner_r
      assign right_d[g] = cell_data[g+1];
    end
    obl_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .left_data  (left_d[g]),
      .right_data (right_d[g]),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  // entry count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) count_r <= res.count_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (fire) out_r <= res.item;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // accepted inserts that succeed, and accepted clears
  assign insert_ok = fire && (res.item.status == ST_OK) &&
                     ((in_data.op == OP_APPEND) || (in_data.op == OP_PREPEND));
  assign clear_req = fire && (in_data.op == OP_CLEAR);

  // checks
  `OBL_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r, "result valid after reset")
  `OBL_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `OBL_ASSERT(a_fire_gives_result, fire |=> out_valid_r, "accepted request gave no result")
  `OBL_ASSERT(a_clear_empties, clear_req |=> (count_r == '0) && out_r.now_empty, "clear left entries")
  `OBL_ASSERT(a_insert_count, insert_ok |=> count_r == $past(count_r) + CNT_W'(1), "insert lost")

endmodule

>>> tb/sv/ordered_block_list_tb.sv
// ----------------------------------------------------------------------------
// ordered_block_list_tb
// Self-checking bench for the ordered block list. A short table of directed
// requests (empty, null, full and duplicate-handle cases, every operation)
// runs first, then a long random stream biased to fill and drain the list.
// A queue model of the replacement order predicts the untyped results (typed
// rows carry their own), compared field by field in order. Both channels idle
// at random, and once the result side holds off long enough to stall input.
// ----------------------------------------------------------------------------
module ordered_block_list_tb;
  import obl_pkg::*;

  localparam int RAND_REQS   = 1810;
  localparam int TAIL_REQS   = 200;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 200;

  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef struct {
    in_item_t  req;
    int        reps;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  handle_t   lru_order[$];        // front of the list at index 0
  out_item_t pending_results[$];
  stim_row_t stim_rows[$];
  handle_t   handle_pool[16];
  int        req_cnt     = 0;
  int        err_cnt     = 0;
  bit        idle_on     = 1'b1;
  bit        tail_mode   = 1'b0;
  bit        hold_active = 1'b0;

  ordered_block_list i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Replacement-order model: apply one request, return its result
  function automatic out_item_t lru_apply(input in_item_t req);
    out_item_t res;
    int        pos;
    handle_t   h;
    res = '0;
    pos = -1;
    h   = req.handle;
    case (req.op)
      OP_APPEND, OP_PREPEND: begin
        if (h == '0) begin
          res.status = ST_NOT_FOUND;
        end else if (lru_order.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (req.op == OP_APPEND) begin
          lru_order.push_back(h);
        end else begin
          lru_order.push_front(h);
        end
      end
      OP_REM_FIRST, OP_REM_LAST: begin
        if (lru_order.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (req.op == OP_REM_FIRST) begin
          res.handle_out = lru_order.pop_front();
        end else begin
          res.handle_out = lru_order.pop_back();
        end
      end
      OP_REMOVE, OP_MOVE_END, OP_MOVE_FRONT: begin
        if (lru_order.size() == 0) begin
          res.status = ST_EMPTY;
        end else if (h == '0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // front-most match wins when a handle is held twice
          for (int i = 0; i < lru_order.size(); i++) begin
            if (pos < 0 && lru_order[i] == h) pos = i;
          end
          if (pos < 0) begin
            res.status = ST_NOT_FOUND;
          end else begin
            lru_order.delete(pos);
            if (req.op == OP_REMOVE) res.handle_out = h;
            else if (req.op == OP_MOVE_END) lru_order.push_back(h);
            else lru_order.push_front(h);
          end
        end
      end
      OP_CLEAR: begin
        lru_order.delete();
      end
    endcase
    res.now_empty   = (lru_order.size() == 0);
    res.entry_count = ENTRY_CNT_W'(lru_order.size());
    return res;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input handle_t h,
                                  input int reps = 1, input bit typed = 1'b0,
                                  input handle_t hout = '0,
                                  input logic [STATUS_W-1:0] st = ST_OK,
                                  input logic emp = 1'b0,
                                  input logic [ENTRY_CNT_W-1:0] cnt = '0);
    stim_row_t row;
    row.req.op             = op;
    row.req.handle         = h;
    row.reps               = reps;
    row.typed              = typed;
    row.res.handle_out     = hout;
    row.res.status         = st;
    row.res.now_empty      = emp;
    row.res.entry_count    = cnt;
    stim_rows.push_back(row);
  endfunction

  // Offer one request, wait for the handshake, then log what must come back
  task automatic send_req(input in_item_t req, input bit typed,
                          input out_item_t typed_res);
    int        gap;
    out_item_t res;
    if (idle_on && !hold_active && !tail_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!(in_valid && in_ready));
    res = lru_apply(req);
    pending_results.push_back(typed ? typed_res : res);
    req_cnt++;
  endtask

  // Insert/remove mix shifts with the fill bias so full and empty both occur
  function automatic logic [OP_W-1:0] pick_op(input int fill_bias);
    int r;
    int ins;
    r   = $urandom_range(0, 99);
    ins = (fill_bias == 2) ? 55 : (fill_bias == 1) ? 35 : 15;
    if (r < 2) return OP_CLEAR;
    if (r < 2 + ins) return ($urandom_range(0, 1) != 0) ? OP_APPEND : OP_PREPEND;
    case ($urandom_range(0, 4))
      0:       return OP_REM_FIRST;
      1:       return OP_REM_LAST;
      2:       return OP_REMOVE;
      3:       return OP_MOVE_END;
      default: return OP_MOVE_FRONT;
    endcase
  endfunction

  // Mostly handles already in the list, so searches hit
  function automatic handle_t pick_handle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && lru_order.size() != 0)
      return lru_order[$urandom_range(0, lru_order.size() - 1)];
    if (r < 85) return handle_pool[$urandom_range(0, 15)];
    if (r < 92) return '0;
    return handle_t'($urandom());
  endfunction

  function automatic void cmp_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual 0x%0h", $time, out_data);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        cmp_field("handle_out", exp_res.handle_out, out_data.handle_out);
        cmp_field("status", exp_res.status, out_data.status);
        cmp_field("now_empty", exp_res.now_empty, out_data.now_empty);
        cmp_field("entry_count", exp_res.entry_count, out_data.entry_count);
      end
    end
  end

  // Result side: random stalls, one long hold-off, none in the tail
  initial begin : drain_ctl
    int burst;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!hold_done && req_cnt >= HOLD_AT) begin
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end else if (!tail_mode && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin : stim
    in_item_t  req;
    out_item_t none;
    int        fill_bias;
    none = '0;
    foreach (handle_pool[i]) handle_pool[i] = handle_t'($urandom());

    // directed table
    add_row(OP_REM_FIRST, '0, 1, 1'b1, '0, ST_EMPTY, 1'b1, 5'd0);
    add_row(OP_REM_LAST, 16'hFFFF, 1, 1'b1, '0, ST_EMPTY, 1'b1, 5'd0);
    add_row(OP_REMOVE, 16'h0001, 1, 1'b1, '0, ST_EMPTY, 1'b1, 5'd0);
    add_row(OP_MOVE_END, 16'h1234, 1, 1'b1, '0, ST_EMPTY, 1'b1, 5'd0);
    add_row(OP_MOVE_FRONT, 16'hFFFF, 1, 1'b1, '0, ST_EMPTY, 1'b1, 5'd0);
    add_row(OP_APPEND, '0, 1, 1'b1, '0, ST_NOT_FOUND, 1'b1, 5'd0);
    add_row(OP_PREPEND, '0, 1, 1'b1, '0, ST_NOT_FOUND, 1'b1, 5'd0);
    add_row(OP_APPEND, 16'hFFFF, 1, 1'b1, '0, ST_OK, 1'b0, 5'd1);
    add_row(OP_PREPEND, 16'h0001, 1, 1'b1, '0, ST_OK, 1'b0, 5'd2);
    add_row(OP_APPEND, 16'hAAAA);
    add_row(OP_APPEND, 16'h5555);
    add_row(OP_PREPEND, 16'hAAAA);   // duplicate handle
    add_row(OP_MOVE_FRONT, 16'h5555);
    add_row(OP_MOVE_END, 16'hAAAA);
    add_row(OP_REMOVE, '0, 1, 1'b1, '0, ST_NOT_FOUND, 1'b0, 5'd5);
    add_row(OP_REMOVE, 16'h1234);
    add_row(OP_REMOVE, 16'hAAAA);
    add_row(OP_REM_FIRST, '0);
    add_row(OP_REM_LAST, '0);
    add_row(OP_CLEAR, '0, 1, 1'b1, '0, ST_OK, 1'b1, 5'd0);
    add_row(OP_APPEND, 16'h8000, CAPACITY);   // fill to capacity
    add_row(OP_APPEND, 16'h7FFF, 1, 1'b1, '0, ST_FULL, 1'b0, ENTRY_CNT_W'(CAPACITY));
    add_row(OP_PREPEND, 16'h7FFF, 1, 1'b1, '0, ST_FULL, 1'b0, ENTRY_CNT_W'(CAPACITY));
    add_row(OP_APPEND, '0, 1, 1'b1, '0, ST_NOT_FOUND, 1'b0, ENTRY_CNT_W'(CAPACITY));
    add_row(OP_MOVE_FRONT, 16'h800F);
    add_row(OP_MOVE_END, 16'h8000);
    add_row(OP_CLEAR, '0, 1, 1'b1, '0, ST_OK, 1'b1, 5'd0);
    add_row(OP_CLEAR, '0, 1, 1'b1, '0, ST_OK, 1'b1, 5'd0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[r]) begin
      for (int k = 0; k < stim_rows[r].reps; k++) begin
        req        = stim_rows[r].req;
        req.handle = req.handle + handle_t'(k);
        send_req(req, stim_rows[r].typed, stim_rows[r].res);
      end
    end

    // random part
    fill_bias = 1;
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n % 100 == 0) begin
        idle_on   = ($urandom_range(0, 2) != 0);
        fill_bias = $urandom_range(0, 2);
      end
      tail_mode  = (n >= RAND_REQS - TAIL_REQS);
      req.op     = pick_op(fill_bias);
      req.handle = pick_handle();
      send_req(req, 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> ordered_block_list.f
+incdir+rtl/core
rtl/core/obl_pkg.sv
rtl/core/obl_cell.sv
rtl/core/obl_ctrl.sv
rtl/core/ordered_block_list.sv
tb/sv/ordered_block_list_tb.sv
